// ===== src/itoa_pkg.sv =====
// Shared types and constants for the integer to ASCII formatter.
// Holds the beat structs, the format selector codes, the sequencer states and character codes.
// No dependencies.
`default_nettype none

package itoa_pkg;

    typedef logic [1:0] t_fmt;

    localparam t_fmt FMT_UDEC = 2'd0;
    localparam t_fmt FMT_SDEC = 2'd1;
    localparam t_fmt FMT_HEX  = 2'd2;
    localparam t_fmt FMT_NONE = 2'd3;

    typedef struct packed {
        t_fmt        req_type;
        logic [31:0] value;
        logic [3:0]  hex_digits;
    } t_in_beat;

    typedef struct packed {
        logic [7:0] ascii_char;
        logic       last;
    } t_out_beat;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SIGN,
        ST_CONV,
        ST_DEC,
        ST_PREFIX,
        ST_HEX
    } t_state;

    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_X     = 8'h78;
    localparam logic [7:0] CH_MINUS = 8'h2d;
    // 'a' minus ten, so that a nibble of ten or more maps straight onto 'a'..'f'
    localparam logic [7:0] CH_HEX_A = 8'h57;
    localparam logic [3:0] NIB_TEN  = 4'd10;

endpackage

`default_nettype wire

// ===== src/integer_to_ascii_formatter.sv =====
// Integer to ASCII formatter: unsigned/signed decimal and 0x-prefixed hex, one character a beat.
// Uses itoa_pkg for beat structs, selector codes, states and character codes.
//
//  channel | dir | handshake                | payload
//  --------+-----+--------------------------+---------------------------------
//  in      | in  | i_in_valid / o_in_stall   | i_in_data  (req_type, value, hex_digits)
//  out     | out | o_out_valid / i_out_stall | o_out_data (ascii_char, last)
//
// Decimal: an accept step, a leading '-' for a negative signed value, then shift-and-add-3
// BCD conversion over all VALUE_BITS input bits on one shared bank of digit adjusters, then
// one character per shown BCD digit, with leading zeros skipped and no beat given for them.
// Hex: accept, '0' and 'x' prefix, one character per digit. The input stalls until the last
// character is loaded into the output register. Reset is synchronous and clears control state.
// A stalled output holds the sequencer while it has a character to load; the conversion and
// the leading-zero skipping run on.
`default_nettype none

module integer_to_ascii_formatter #(
    parameter int VALUE_BITS = 32
) (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire                   i_in_valid,
    output logic                  o_in_stall,
    input  wire itoa_pkg::t_in_beat i_in_data,
    output logic                  o_out_valid,
    input  wire                   i_out_stall,
    output itoa_pkg::t_out_beat   o_out_data
);

    localparam int NUM_DIGITS = (VALUE_BITS * 30103) / 100000 + 1;
    localparam int BCD_W      = NUM_DIGITS * 4;
    localparam int NUM_NIBS   = (VALUE_BITS + 3) / 4;
    localparam int HEX_W      = NUM_NIBS * 4;
    localparam int CNT_W      = $clog2(VALUE_BITS + 1);
    localparam int NIB_IDX_W  = (NUM_NIBS > 1) ? $clog2(NUM_NIBS) : 1;

    itoa_pkg::t_state    r_state, n_state;
    logic [VALUE_BITS-1:0] r_bin, n_bin;
    logic [BCD_W-1:0]    r_bcd, n_bcd;
    logic [CNT_W-1:0]    r_cnt, n_cnt;
    logic                r_seen, n_seen;
    logic                r_x, n_x;
    logic                r_out_valid, n_out_valid;
    itoa_pkg::t_out_beat r_out_data, n_out_data;

    logic                  accept;
    logic                  can_emit;
    logic [VALUE_BITS-1:0] in_val;
    logic [VALUE_BITS-1:0] in_neg;
    logic [CNT_W-1:0]      nd_in;
    logic [CNT_W-1:0]      nd_sat;
    logic [BCD_W-1:0]      bcd_adj;
    logic [3:0]            top_dig;
    logic                  show;
    logic [HEX_W-1:0]      hex_vec;
    logic [CNT_W-1:0]      cnt_dec;
    logic [3:0]            nib;

    assign o_in_stall  = (r_state != itoa_pkg::ST_IDLE);
    assign accept      = i_in_valid && !o_in_stall;
    assign can_emit    = !r_out_valid || !i_out_stall;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    assign in_val  = VALUE_BITS'(i_in_data.value);
    assign in_neg  = VALUE_BITS'(0) - in_val;
    assign nd_in   = CNT_W'(i_in_data.hex_digits);
    assign nd_sat  = (nd_in > CNT_W'(NUM_NIBS)) ? CNT_W'(NUM_NIBS) : nd_in;
    assign top_dig = r_bcd[BCD_W-1 -: 4];
    assign show    = (top_dig != 4'd0) || r_seen || (r_cnt == CNT_W'(1));
    assign hex_vec = HEX_W'(r_bin);
    assign cnt_dec = r_cnt - CNT_W'(1);
    assign nib     = hex_vec[cnt_dec[NIB_IDX_W-1:0]*4 +: 4];

    // add 3 to every BCD digit of five or more ahead of the shift
    always_comb begin
        for (int d = 0; d < NUM_DIGITS; d++) begin
            if (r_bcd[d*4 +: 4] >= 4'd5) begin
                bcd_adj[d*4 +: 4] = r_bcd[d*4 +: 4] + 4'd3;
            end else begin
                bcd_adj[d*4 +: 4] = r_bcd[d*4 +: 4];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= itoa_pkg::ST_IDLE;
            r_out_valid <= 1'b0;
            r_cnt       <= '0;
            r_seen      <= 1'b0;
            r_x         <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_cnt       <= n_cnt;
            r_seen      <= n_seen;
            r_x         <= n_x;
        end
    end

    always_ff @(posedge i_clk) begin
        r_bin      <= n_bin;
        r_bcd      <= n_bcd;
        r_out_data <= n_out_data;
    end

    always_comb begin
        n_state     = r_state;
        n_bin       = r_bin;
        n_bcd       = r_bcd;
        n_cnt       = r_cnt;
        n_seen      = r_seen;
        n_x         = r_x;
        n_out_valid = r_out_valid && i_out_stall;
        n_out_data  = r_out_data;

        case (r_state)
            itoa_pkg::ST_IDLE: begin
                if (accept) begin
                    n_bin  = in_val;
                    n_bcd  = '0;
                    n_cnt  = CNT_W'(VALUE_BITS);
                    n_seen = 1'b0;
                    n_x    = 1'b0;
                    case (i_in_data.req_type)
                        itoa_pkg::FMT_UDEC: n_state = itoa_pkg::ST_CONV;
                        itoa_pkg::FMT_SDEC: begin
                            if (in_val[VALUE_BITS-1]) begin
                                n_bin   = in_neg;
                                n_state = itoa_pkg::ST_SIGN;
                            end else begin
                                n_state = itoa_pkg::ST_CONV;
                            end
                        end
                        itoa_pkg::FMT_HEX: begin
                            n_cnt   = nd_sat;
                            n_state = itoa_pkg::ST_PREFIX;
                        end
                        default: n_state = itoa_pkg::ST_IDLE;
                    endcase
                end
            end
            itoa_pkg::ST_SIGN: begin
                if (can_emit) begin
                    n_out_valid           = 1'b1;
                    n_out_data.ascii_char = itoa_pkg::CH_MINUS;
                    n_out_data.last       = 1'b0;
                    n_state               = itoa_pkg::ST_CONV;
                end
            end
            itoa_pkg::ST_CONV: begin
                n_bcd = {bcd_adj[BCD_W-2:0], r_bin[VALUE_BITS-1]};
                n_bin = {r_bin[VALUE_BITS-2:0], 1'b0};
                n_cnt = cnt_dec;
                if (r_cnt == CNT_W'(1)) begin
                    n_cnt   = CNT_W'(NUM_DIGITS);
                    n_state = itoa_pkg::ST_DEC;
                end
            end
            itoa_pkg::ST_DEC: begin
                // drop leading zeros without a beat; hold while a digit waits on the output
                if (!show || can_emit) begin
                    if (show) begin
                        n_out_valid           = 1'b1;
                        n_out_data.ascii_char = itoa_pkg::CH_ZERO + {4'd0, top_dig};
                        n_out_data.last       = (r_cnt == CNT_W'(1));
                        n_seen                = 1'b1;
                    end
                    n_bcd = {r_bcd[BCD_W-5:0], 4'd0};
                    n_cnt = cnt_dec;
                    if (r_cnt == CNT_W'(1)) begin
                        n_state = itoa_pkg::ST_IDLE;
                    end
                end
            end
            itoa_pkg::ST_PREFIX: begin
                if (can_emit) begin
                    n_out_valid = 1'b1;
                    if (!r_x) begin
                        n_out_data.ascii_char = itoa_pkg::CH_ZERO;
                        n_out_data.last       = 1'b0;
                        n_x                   = 1'b1;
                    end else begin
                        n_out_data.ascii_char = itoa_pkg::CH_X;
                        n_out_data.last       = (r_cnt == '0);
                        n_state = (r_cnt == '0) ? itoa_pkg::ST_IDLE : itoa_pkg::ST_HEX;
                    end
                end
            end
            itoa_pkg::ST_HEX: begin
                if (can_emit) begin
                    n_out_valid = 1'b1;
                    if (nib < itoa_pkg::NIB_TEN) begin
                        n_out_data.ascii_char = itoa_pkg::CH_ZERO + {4'd0, nib};
                    end else begin
                        n_out_data.ascii_char = itoa_pkg::CH_HEX_A + {4'd0, nib};
                    end
                    n_out_data.last = (r_cnt == CNT_W'(1));
                    n_cnt           = cnt_dec;
                    if (r_cnt == CNT_W'(1)) begin
                        n_state = itoa_pkg::ST_IDLE;
                    end
                end
            end
            default: n_state = itoa_pkg::ST_IDLE;
        endcase
    end

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_in_data.req_type != itoa_pkg::FMT_NONE) |=> o_in_stall)
        else $error("formatter did not leave idle after a request");

    a_conv_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == itoa_pkg::ST_CONV) |-> (r_cnt != '0))
        else $error("conversion counter ran out");

    a_hex_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == itoa_pkg::ST_HEX) |-> (r_cnt != '0 && r_cnt <= CNT_W'(NUM_NIBS)))
        else $error("hex digit count out of range");

    a_final_digit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == itoa_pkg::ST_DEC && r_cnt == CNT_W'(1) && can_emit)
        |=> (o_out_valid && o_out_data.last))
        else $error("final decimal digit not flagged");

endmodule

`default_nettype wire
